### rtl/dram_channel_command_timer_assert.svh
// Assertion macros used by the DRAM channel timer engine.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef DRAM_CHANNEL_COMMAND_TIMER_ASSERT_SVH
`define DRAM_CHANNEL_COMMAND_TIMER_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define DCT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define DCT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/dct_pkg.sv
// Shared types and constants of the DRAM channel command timer.
// No dependencies; the front, engine and top files refer to it by scoped names.
`default_nettype none
package dct_pkg;

  localparam int BURST_BYTES = 64;
  localparam int COLUMN_BITS = 10;
  localparam int ROW_BITS    = 15;
  localparam int RANK_BITS   = 1;
  localparam int QUEUE_DEPTH = 16;

  localparam int NUM_RANKS   = 1 << RANK_BITS;
  localparam int RANK_W      = (RANK_BITS > 0) ? RANK_BITS : 1;
  localparam int BURST_SHIFT = $clog2(BURST_BYTES);
  localparam int ROW_SHIFT   = BURST_SHIFT + COLUMN_BITS;
  localparam int RANK_SHIFT  = ROW_SHIFT + ROW_BITS;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W = 48;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 13;
  localparam int CMD_W  = 2;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ISSUE_NONE      = 3'd0,
    ISSUE_PRECHARGE = 3'd1,
    ISSUE_ACTIVATE  = 3'd2,
    ISSUE_READ      = 3'd3,
    ISSUE_WRITE     = 3'd4
  } issue_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_CAS_LATENCY   = 3'd0,
    REG_ACT_TO_ACCESS = 3'd1,
    REG_PRECHARGE     = 3'd2,
    REG_ACT_TO_PRE    = 3'd3,
    REG_WRITE_LAT     = 3'd4,
    REG_BURST_TO_BURST= 3'd5,
    REG_WRITE_RECOVERY= 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    cmd_t              kind;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  typedef struct packed {
    logic                accepted;
    issue_t              issued_command;
    logic                issued_rank;
    logic [ROW_BITS-1:0] issued_row;
    logic                read_done;
    logic [ADDR_W-1:0]   done_address;
    logic [SIZE_W-1:0]   done_size;
    logic                busy_res;
  } result_t;

endpackage
`default_nettype wire

### rtl/dct_front.sv
// Front end of the DRAM channel timer: packs incoming words into items and buffers
// them in a two-entry queue. Depends on dct_pkg.
`default_nettype none
module dct_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dct_pkg::CMD_W-1:0]     command,
  input  wire logic [dct_pkg::ADDR_W-1:0]    address,
  input  wire logic [dct_pkg::SIZE_W-1:0]    size,
  output dct_pkg::front_out_t                front,
  input  wire logic                          pop
);

  dct_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  dct_pkg::item_t incoming;

  always_comb begin
    incoming.kind    = dct_pkg::cmd_t'(command);
    incoming.address = address;
    incoming.size    = size;
  end

  assign in_ready    = (count != 2'd2);
  assign push        = in_valid && in_ready;
  assign front.valid = (count != 2'd0);
  assign front.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/dct_engine.sv
// Back end of the DRAM channel timer: timing state, row tracking, command
// issue and the read completion queue. Depends on dct_pkg and the assert header.
`default_nettype none
`include "dram_channel_command_timer_assert.svh"
module dct_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dct_pkg::front_out_t           front,
  output logic                               pop,
  input  wire logic                          cfg_valid,
  input  wire logic [dct_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [dct_pkg::CDAT_W-1:0]    cfg_data,
  output dct_pkg::result_t                   result,
  output logic                               result_valid,
  input  wire logic                          result_ready
);

  localparam int TW = dct_pkg::TIME_W;
  localparam int AW = dct_pkg::ADDR_W;
  localparam int SW = dct_pkg::SIZE_W;
  localparam int RW = dct_pkg::ROW_BITS;
  localparam int KW = dct_pkg::RANK_W;
  localparam int PW = dct_pkg::QPTR_W;
  localparam int CW = dct_pkg::QCNT_W;

  // Configuration registers.
  logic [3:0] cas_latency;
  logic [7:0] act_to_access, precharge_time, act_to_pre;
  logic [7:0] write_latency, burst_to_burst, write_recovery;

  // Channel state. cur_addr is address plus offset and remain is what is left.
  logic [TW-1:0] tick_count, next_cmd_time, next_pre_time;
  logic          busy;
  logic [AW-1:0] act_address, cur_addr;
  logic [SW-1:0] act_size, remain;
  logic          act_write;
  logic [RW-1:0] open_row [dct_pkg::NUM_RANKS];
  logic [dct_pkg::NUM_RANKS-1:0] row_valid;

  // Completion queue.
  logic [AW-1:0] q_addr [dct_pkg::QUEUE_DEPTH];
  logic [SW-1:0] q_size [dct_pkg::QUEUE_DEPTH];
  logic [TW-1:0] q_time [dct_pkg::QUEUE_DEPTH];
  logic [PW-1:0] q_head, q_tail;
  logic [CW-1:0] q_count;

  logic fire, is_tick, is_req, take;
  logic q_pop, q_push;
  logic [CW-1:0] count_after_pop;
  logic [AW-1:0] rank_bits, row_bits;
  logic [KW-1:0] rank;
  logic [RW-1:0] row;
  logic [SW-1:0] chunk_full, chunk;
  logic last, hit;
  dct_pkg::result_t res;

  logic [TW-1:0] next_cmd_time_next, next_pre_time_next, start_time;
  logic          busy_next, row_valid_clr, row_valid_set, adv;

  assign fire    = front.valid && (!result_valid || result_ready);
  assign pop     = fire;
  assign is_tick = (front.item.kind == dct_pkg::CMD_TICK);
  assign is_req  = (front.item.kind == dct_pkg::CMD_READ) ||
                   (front.item.kind == dct_pkg::CMD_WRITE);
  assign take    = fire && is_req && !busy;

  assign rank_bits = cur_addr >> dct_pkg::RANK_SHIFT;
  assign row_bits  = cur_addr >> dct_pkg::ROW_SHIFT;
  assign rank      = rank_bits[KW-1:0] & KW'(dct_pkg::NUM_RANKS - 1);
  assign row       = row_bits[RW-1:0];
  assign hit       = row_valid[rank] && (open_row[rank] == row);

  assign chunk_full = SW'(dct_pkg::BURST_BYTES) - SW'(cur_addr[dct_pkg::BURST_SHIFT-1:0]);
  assign chunk      = (chunk_full > remain) ? remain : chunk_full;
  assign last       = (chunk >= remain);

  assign q_pop = fire && is_tick && (q_count != '0) && (q_time[q_head] <= tick_count);
  assign count_after_pop = q_count - CW'(q_pop);

  always_comb begin
    res                = '0;
    res.issued_command = dct_pkg::ISSUE_NONE;
    next_cmd_time_next = next_cmd_time;
    next_pre_time_next = next_pre_time;
    busy_next          = busy;
    row_valid_clr      = 1'b0;
    row_valid_set      = 1'b0;
    adv                = 1'b0;
    q_push             = 1'b0;
    start_time         = (next_pre_time > tick_count) ? next_pre_time : tick_count;
    if (take) begin
      res.accepted       = 1'b1;
      next_cmd_time_next = '0;
      busy_next          = 1'b1;
    end
    if (q_pop) begin
      res.read_done    = 1'b1;
      res.done_address = q_addr[q_head];
      res.done_size    = q_size[q_head];
    end
    if (fire && is_tick && busy && (tick_count >= next_cmd_time)) begin
      if (!hit) begin
        res.issued_rank = rank[0];
        if (row_valid[rank]) begin
          res.issued_command = dct_pkg::ISSUE_PRECHARGE;
          res.issued_row     = open_row[rank];
          next_cmd_time_next = start_time + TW'(precharge_time);
          row_valid_clr      = 1'b1;
        end else begin
          res.issued_command = dct_pkg::ISSUE_ACTIVATE;
          res.issued_row     = row;
          next_cmd_time_next = tick_count + TW'(act_to_access);
          next_pre_time_next = tick_count + TW'(act_to_pre);
          row_valid_set      = 1'b1;
        end
      end else if (act_write) begin
        res.issued_command = dct_pkg::ISSUE_WRITE;
        res.issued_rank    = rank[0];
        res.issued_row     = row;
        next_cmd_time_next = tick_count + TW'(write_latency);
        next_pre_time_next = tick_count + TW'(write_recovery);
        adv                = 1'b1;
        busy_next          = !last;
      end else if (!(last && (count_after_pop >= CW'(dct_pkg::QUEUE_DEPTH)))) begin
        res.issued_command = dct_pkg::ISSUE_READ;
        res.issued_rank    = rank[0];
        res.issued_row     = row;
        next_cmd_time_next = tick_count + TW'(burst_to_burst);
        adv                = 1'b1;
        q_push             = last;
        busy_next          = !last;
      end
    end
    res.busy_res = busy_next;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
    if (take) begin
      act_address <= front.item.address;
      cur_addr    <= front.item.address;
      act_size    <= front.item.size;
      remain      <= front.item.size;
      act_write   <= (front.item.kind == dct_pkg::CMD_WRITE);
    end
    if (adv) begin
      cur_addr <= cur_addr + AW'(chunk);
      remain   <= remain - chunk;
    end
    if (row_valid_set) begin
      open_row[rank] <= row;
    end
    if (q_push) begin
      q_addr[q_tail] <= act_address;
      q_size[q_tail] <= act_size;
      q_time[q_tail] <= tick_count + TW'(cas_latency);
    end
    if (rst) begin
      cas_latency    <= 4'd11;
      act_to_access  <= 8'd11;
      precharge_time <= 8'd11;
      act_to_pre     <= 8'd28;
      write_latency  <= 8'd8;
      burst_to_burst <= 8'd4;
      write_recovery <= 8'd12;
      tick_count     <= '0;
      next_cmd_time  <= '0;
      next_pre_time  <= '0;
      busy           <= 1'b0;
      row_valid      <= '0;
      q_head         <= '0;
      q_tail         <= '0;
      q_count        <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (dct_pkg::reg_idx_t'(cfg_index))
          dct_pkg::REG_CAS_LATENCY:    cas_latency    <= cfg_data[3:0];
          dct_pkg::REG_ACT_TO_ACCESS:  act_to_access  <= cfg_data;
          dct_pkg::REG_PRECHARGE:      precharge_time <= cfg_data;
          dct_pkg::REG_ACT_TO_PRE:     act_to_pre     <= cfg_data;
          dct_pkg::REG_WRITE_LAT:      write_latency  <= cfg_data;
          dct_pkg::REG_BURST_TO_BURST: burst_to_burst <= cfg_data;
          dct_pkg::REG_WRITE_RECOVERY: write_recovery <= cfg_data;
          default: begin
          end
        endcase
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (fire && is_tick) begin
        tick_count <= tick_count + TW'(1);
      end
      next_cmd_time <= next_cmd_time_next;
      next_pre_time <= next_pre_time_next;
      busy          <= busy_next;
      if (row_valid_clr) begin
        row_valid[rank] <= 1'b0;
      end
      if (row_valid_set) begin
        row_valid[rank] <= 1'b1;
      end
      if (q_pop) begin
        q_head <= (q_head == PW'(dct_pkg::QUEUE_DEPTH - 1)) ? '0 : q_head + PW'(1);
      end
      if (q_push) begin
        q_tail <= (q_tail == PW'(dct_pkg::QUEUE_DEPTH - 1)) ? '0 : q_tail + PW'(1);
      end
      q_count <= q_count + CW'(q_push) - CW'(q_pop);
    end
  end

  `DCT_ASSERT_ALWAYS(a_queue_bound, q_count <= CW'(dct_pkg::QUEUE_DEPTH), "queue overfilled")
  `DCT_ASSERT_NEXT(a_take_busy, take, busy, "accepted request did not mark channel busy")
  `DCT_ASSERT_NEXT(a_fire_result, fire, result_valid, "processed word gave no result")
  `DCT_ASSERT_NEXT(a_push_count, q_push && !q_pop, q_count == $past(q_count) + CW'(1), "queue count slip")

endmodule
`default_nettype wire

### rtl/dram_channel_command_timer.sv
// Top level of the DRAM channel command timer.
// Depends on dct_pkg, dct_front and dct_engine.
//
// Usage: words arrive on the input channel (in_valid/in_ready) carrying
// command, address and size. A command of 0 or 1 offers a read or write
// request, which is taken only while the channel is idle; a command of 2 is
// one controller tick, on which at most one DRAM command is issued and at
// most one finished read is reported. Every input word yields exactly one
// result word on the output channel (out_valid/out_ready).
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it. cfg_ready is always high. An accepted
// word waits in the two-entry input queue and then passes through the
// execution engine, whose output register holds the result. Throughput is
// one word per cycle while the receiver takes each result. When the receiver
// stalls, the result stays in the output register and the input queue fills,
// after which in_ready falls. Synchronous reset restores the register
// defaults, closes all rows, empties both queues and drops out_valid.
`default_nettype none
module dram_channel_command_timer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dct_pkg::CMD_W-1:0]          command,
  input  wire logic [dct_pkg::ADDR_W-1:0]         address,
  input  wire logic [dct_pkg::SIZE_W-1:0]         size,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    accepted,
  output logic [2:0]                              issued_command,
  output logic                                    issued_rank,
  output logic [dct_pkg::ROW_BITS-1:0]            issued_row,
  output logic                                    read_done,
  output logic [dct_pkg::ADDR_W-1:0]              done_address,
  output logic [dct_pkg::SIZE_W-1:0]              done_size,
  output logic                                    busy_res,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dct_pkg::CIDX_W-1:0]         cfg_index,
  input  wire logic [dct_pkg::CDAT_W-1:0]         cfg_data
);

  dct_pkg::front_out_t front;
  dct_pkg::result_t    result;
  logic                pop;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  dct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .address  (address),
    .size     (size),
    .front    (front),
    .pop      (pop)
  );

  dct_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .front        (front),
    .pop          (pop),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (out_valid),
    .result_ready (out_ready)
  );

  // The result word is unpacked onto one port per field.
  assign accepted       = result.accepted;
  assign issued_command = result.issued_command;
  assign issued_rank    = result.issued_rank;
  assign issued_row     = result.issued_row;
  assign read_done      = result.read_done;
  assign done_address   = result.done_address;
  assign done_size      = result.done_size;
  assign busy_res       = result.busy_res;

endmodule
`default_nettype wire
